// ----- src/cvm_pkg.sv -----
// ----------------------------------------------------------------------------
// cvm_pkg
// Beat types and operator and error codes for the CIGAR checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cvm_pkg;

    localparam logic [3:0] OP_M  = 4'd0;
    localparam logic [3:0] OP_I  = 4'd1;
    localparam logic [3:0] OP_D  = 4'd2;
    localparam logic [3:0] OP_N  = 4'd3;
    localparam logic [3:0] OP_S  = 4'd4;
    localparam logic [3:0] OP_H  = 4'd5;
    localparam logic [3:0] OP_P  = 4'd6;
    localparam logic [3:0] OP_EQ = 4'd7;
    localparam logic [3:0] OP_X  = 4'd8;

    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_EMPTY       = 4'd1;
    localparam logic [3:0] ERR_ZERO_LENGTH = 4'd2;
    localparam logic [3:0] ERR_HARD_CLIP   = 4'd3;
    localparam logic [3:0] ERR_SOFT_CLIP   = 4'd4;
    localparam logic [3:0] ERR_INDEL_REP   = 4'd5;
    localparam logic [3:0] ERR_PAD_END     = 4'd6;
    localparam logic [3:0] ERR_PAD_NEIGH   = 4'd7;
    localparam logic [3:0] ERR_NO_REAL_OP  = 4'd8;

    localparam logic [15:0] SOFT_AT_ONE_COUNT = 16'd3;

    typedef struct packed {
        logic [3:0]  operation_code;
        logic [27:0] operation_length;
        logic [15:0] element_count;
    } cvm_in_t;

    typedef struct packed {
        logic        record_valid;
        logic [3:0]  error_code;
        logic [15:0] error_index;
        logic [31:0] read_length;
        logic [31:0] reference_length;
        logic [31:0] padded_reference_length;
    } cvm_out_t;

endpackage

`default_nettype wire

// ----- src/cigar_validate_and_measure.sv -----
// ----------------------------------------------------------------------------
// cigar_validate_and_measure
// Checks one CIGAR per record against the SAM rules and measures its lengths.
// ----------------------------------------------------------------------------
// One CIGAR element is taken per beat and a new beat can be taken in every
// cycle unless a result waiting on m_ready holds a last element behind it;
// other elements keep flowing. A beat passes through an input register, one
// pass of flag and adder logic and the result register, so the result of a
// record's last element is registered as that element's beat is consumed.
`default_nettype none

module cigar_validate_and_measure #(
    parameter logic [31:0] MAX_ELEMENTS    = 32'd65535,
    parameter int          LENGTH_SUM_BITS = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire cvm_pkg::cvm_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output cvm_pkg::cvm_out_t     m_data
);
    import cvm_pkg::*;

    localparam int SB = LENGTH_SUM_BITS;
    localparam int AW = ((SB > 28) ? SB : 28) + 1;
    localparam logic [AW-1:0] SUM_LIM = {{(AW - SB){1'b0}}, {SB{1'b1}}};

    function automatic logic is_real(input logic [3:0] op);
        return op == OP_M || op == OP_I || op == OP_D || op == OP_N ||
               op == OP_EQ || op == OP_X;
    endfunction

    function automatic logic [SB-1:0] sat_add(input logic [SB-1:0] a,
                                              input logic [27:0]   b);
        logic [AW-1:0] s;
        s = AW'(a) + AW'(b);
        return (s > SUM_LIM) ? {SB{1'b1}} : s[SB-1:0];
    endfunction

    function automatic logic [31:0] clip32(input logic [SB-1:0] a);
        logic [63:0] v;
        v = 64'(a);
        return (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    cvm_in_t     in_reg;
    logic        in_valid_reg;
    cvm_out_t    out_reg, out_next;
    logic        out_valid_reg;

    logic [15:0] element_index_reg, element_index_next;
    logic        seen_real_reg, seen_real_next;
    logic [3:0]  first_op_reg, first_op_next;
    logic [3:0]  prev_op_reg, prev_op_next;
    logic        pend_pad_reg, pend_pad_next;
    logic        pend_soft_reg, pend_soft_next;
    logic        ins_valid_reg, ins_valid_next;
    logic [15:0] ins_index_reg, ins_index_next;
    logic        del_valid_reg, del_valid_next;
    logic [15:0] del_index_reg, del_index_next;
    logic [3:0]  err_code_reg, err_code_next;
    logic [15:0] err_index_reg, err_index_next;
    logic [SB-1:0] read_sum_reg, read_sum_next;
    logic [SB-1:0] ref_sum_reg, ref_sum_next;
    logic [SB-1:0] pad_sum_reg, pad_sum_next;

    logic        fire, produce, last, clear_state;
    logic [15:0] cnt, idx, idx_m1;
    logic [3:0]  op;
    logic [27:0] len;

    always_comb begin
        op     = in_reg.operation_code;
        len    = in_reg.operation_length;
        idx    = element_index_reg;
        idx_m1 = idx - 16'd1;
        if (32'(in_reg.element_count) > MAX_ELEMENTS) begin
            cnt = MAX_ELEMENTS[15:0];
        end else begin
            cnt = in_reg.element_count;
        end
        last    = ({1'b0, idx} + 17'd1) >= {1'b0, cnt};
        produce = (cnt == 16'd0) || last;
        fire    = in_valid_reg && (!produce || !out_valid_reg || m_ready);

        element_index_next = idx + 16'd1;
        seen_real_next     = seen_real_reg;
        first_op_next      = (idx == 16'd0) ? op : first_op_reg;
        prev_op_next       = op;
        pend_pad_next      = 1'b0;
        pend_soft_next     = 1'b0;
        ins_valid_next     = ins_valid_reg;
        ins_index_next     = ins_index_reg;
        del_valid_next     = del_valid_reg;
        del_index_next     = del_index_reg;
        err_code_next      = err_code_reg;
        err_index_next     = err_index_reg;
        clear_state        = 1'b0;
        out_next           = '0;

        if (len == 28'd0) begin
            err_code_next  = ERR_ZERO_LENGTH;
            err_index_next = (err_code_reg == ERR_NONE || idx < err_index_reg) ?
                             idx : err_index_reg;
            if (!(err_code_reg == ERR_NONE || idx < err_index_reg)) begin
                err_code_next = err_code_reg;
            end
        end
        if (pend_pad_reg && !is_real(op) &&
            (err_code_next == ERR_NONE || idx_m1 < err_index_next)) begin
            err_code_next  = ERR_PAD_NEIGH;
            err_index_next = idx_m1;
        end
        if (pend_soft_reg && op != OP_H &&
            (err_code_next == ERR_NONE || idx_m1 < err_index_next)) begin
            err_code_next  = ERR_SOFT_CLIP;
            err_index_next = idx_m1;
        end
        if (last && idx >= 16'd3 && prev_op_reg == OP_S && op != OP_H &&
            (err_code_next == ERR_NONE || idx_m1 < err_index_next)) begin
            err_code_next  = ERR_SOFT_CLIP;
            err_index_next = idx_m1;
        end

        if (op == OP_H) begin
            if (idx != 16'd0 && !last &&
                (err_code_next == ERR_NONE || idx < err_index_next)) begin
                err_code_next  = ERR_HARD_CLIP;
                err_index_next = idx;
            end
        end else if (op == OP_S) begin
            if (idx == 16'd0 || last) begin
                pend_soft_next = 1'b0;
            end else if (idx == 16'd1) begin
                if (first_op_reg != OP_H) begin
                    if (cnt == SOFT_AT_ONE_COUNT) begin
                        pend_soft_next = 1'b1;
                    end else if (err_code_next == ERR_NONE || idx < err_index_next) begin
                        err_code_next  = ERR_SOFT_CLIP;
                        err_index_next = idx;
                    end
                end
            end else if (({1'b0, idx} + 17'd2) == {1'b0, cnt}) begin
                pend_soft_next = 1'b0;
            end else if (err_code_next == ERR_NONE || idx < err_index_next) begin
                err_code_next  = ERR_SOFT_CLIP;
                err_index_next = idx;
            end
        end else if (is_real(op)) begin
            seen_real_next = 1'b1;
            if (op == OP_I) begin
                if (ins_valid_reg) begin
                    if (err_code_next == ERR_NONE || ins_index_reg < err_index_next) begin
                        err_code_next  = ERR_INDEL_REP;
                        err_index_next = ins_index_reg;
                    end
                end else begin
                    ins_valid_next = 1'b1;
                    ins_index_next = idx;
                end
            end else if (op == OP_D) begin
                if (del_valid_reg) begin
                    if (err_code_next == ERR_NONE || del_index_reg < err_index_next) begin
                        err_code_next  = ERR_INDEL_REP;
                        err_index_next = del_index_reg;
                    end
                end else begin
                    del_valid_next = 1'b1;
                    del_index_next = idx;
                end
            end else begin
                ins_valid_next = 1'b0;
                del_valid_next = 1'b0;
            end
        end else if (op == OP_P) begin
            ins_valid_next = 1'b0;
            del_valid_next = 1'b0;
            if (idx != 16'd0) begin
                if (last) begin
                    if (err_code_next == ERR_NONE || idx < err_index_next) begin
                        err_code_next  = ERR_PAD_END;
                        err_index_next = idx;
                    end
                end else if (!is_real(prev_op_reg)) begin
                    if (err_code_next == ERR_NONE || idx < err_index_next) begin
                        err_code_next  = ERR_PAD_NEIGH;
                        err_index_next = idx;
                    end
                end else begin
                    pend_pad_next = 1'b1;
                end
            end
        end

        read_sum_next = read_sum_reg;
        ref_sum_next  = ref_sum_reg;
        pad_sum_next  = pad_sum_reg;
        if (op == OP_M || op == OP_I || op == OP_S || op == OP_EQ || op == OP_X) begin
            read_sum_next = sat_add(read_sum_reg, len);
        end
        if (op == OP_M || op == OP_D || op == OP_N || op == OP_EQ || op == OP_X) begin
            ref_sum_next = sat_add(ref_sum_reg, len);
            pad_sum_next = sat_add(pad_sum_reg, len);
        end
        if (op == OP_P) begin
            pad_sum_next = sat_add(pad_sum_reg, len);
        end

        if (cnt == 16'd0) begin
            clear_state         = 1'b1;
            out_next.error_code = ERR_EMPTY;
        end else if (last) begin
            clear_state = 1'b1;
            if (err_code_next == ERR_NONE && !seen_real_next) begin
                err_code_next  = ERR_NO_REAL_OP;
                err_index_next = 16'd0;
            end
            out_next.record_valid = (err_code_next == ERR_NONE);
            out_next.error_code   = err_code_next;
            out_next.error_index  = (err_code_next == ERR_NONE) ? 16'd0 : err_index_next;
            out_next.read_length  = clip32(read_sum_next);
            out_next.reference_length        = clip32(ref_sum_next);
            out_next.padded_reference_length = clip32(pad_sum_next);
        end
    end

    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire && produce) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (fire && produce) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && clear_state)) begin
            element_index_reg <= '0;
            seen_real_reg     <= 1'b0;
            first_op_reg      <= OP_M;
            prev_op_reg       <= OP_M;
            pend_pad_reg      <= 1'b0;
            pend_soft_reg     <= 1'b0;
            ins_valid_reg     <= 1'b0;
            ins_index_reg     <= '0;
            del_valid_reg     <= 1'b0;
            del_index_reg     <= '0;
            err_code_reg      <= ERR_NONE;
            err_index_reg     <= '1;
            read_sum_reg      <= '0;
            ref_sum_reg       <= '0;
            pad_sum_reg       <= '0;
        end else if (fire) begin
            element_index_reg <= element_index_next;
            seen_real_reg     <= seen_real_next;
            first_op_reg      <= first_op_next;
            prev_op_reg       <= prev_op_next;
            pend_pad_reg      <= pend_pad_next;
            pend_soft_reg     <= pend_soft_next;
            ins_valid_reg     <= ins_valid_next;
            ins_index_reg     <= ins_index_next;
            del_valid_reg     <= del_valid_next;
            del_index_reg     <= del_index_next;
            err_code_reg      <= err_code_next;
            err_index_reg     <= err_index_next;
            read_sum_reg      <= read_sum_next;
            ref_sum_reg       <= ref_sum_next;
            pad_sum_reg       <= pad_sum_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/cvm_checker.sv -----
// ----------------------------------------------------------------------------
// cvm_port_checks
// Port-level checks on the result beats of the CIGAR checker.
// ----------------------------------------------------------------------------
`default_nettype none

module cvm_port_checks (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire cvm_pkg::cvm_out_t m_data
);
    import cvm_pkg::*;

    // hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_valid_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.record_valid == (m_data.error_code == ERR_NONE))
        else $error("record_valid disagrees with error_code");

    a_clean_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.record_valid |-> m_data.error_index == 16'd0)
        else $error("error_index set on a valid record");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code == ERR_EMPTY |->
            m_data.error_index == 16'd0 && m_data.read_length == 32'd0 &&
            m_data.reference_length == 32'd0 &&
            m_data.padded_reference_length == 32'd0)
        else $error("empty record carries data");

    a_padded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.padded_reference_length >= m_data.reference_length)
        else $error("padded length below reference length");

endmodule

bind cigar_validate_and_measure cvm_port_checks u_cvm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
